// ----- src/bdl_pkg.sv -----
// ============================================================================
// bdl_pkg: shared types, constants and functions for the lexer.
// It holds the request structs, the scanner state codes, the token kinds and
// the keyword table.
// ============================================================================
package bdl_pkg;

  // Default number of identifier characters kept for keyword matching.
  localparam int unsigned KeywordCharsDef = 8;
  // Depth of the queue between the scanner and the output side.
  localparam int unsigned QueueDepth = 4;
  // Most results that one request can cause.
  localparam int unsigned MaxResults = 3;

  // One input request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_file;
  } bdl_in_t;

  // One result request.
  typedef struct packed {
    logic       is_lexeme_char;
    logic [7:0] char_value;
    logic [5:0] token_kind;
    logic       last_result;
  } bdl_out_t;

  // Up to three results made by one input request.
  typedef struct packed {
    logic [1:0] count;
    bdl_out_t   r0;
    bdl_out_t   r1;
    bdl_out_t   r2;
  } bdl_bundle_t;

  // Scanner states.
  typedef enum logic [3:0] {
    S_START = 4'd0,
    S_ID    = 4'd1,
    S_INT   = 4'd2,
    S_DBL   = 4'd3,
    S_EXPW  = 4'd4,
    S_OP    = 4'd5,
    S_BANG  = 4'd6,
    S_STR   = 4'd7,
    S_ESC   = 4'd8,
    S_DDD   = 4'd9,
    S_LCOM  = 4'd10,
    S_SLASH = 4'd11,
    S_BCOM  = 4'd12
  } bdl_state_e;

  // Token kinds used by name in the logic.
  localparam logic [5:0] K_ERR = 6'd0;
  localparam logic [5:0] K_EOL = 6'd1;
  localparam logic [5:0] K_EOF = 6'd2;
  localparam logic [5:0] K_ID  = 6'd3;
  localparam logic [5:0] K_INT = 6'd4;
  localparam logic [5:0] K_DBL = 6'd5;
  localparam logic [5:0] K_STR = 6'd6;
  localparam logic [5:0] K_EQ  = 6'd7;
  localparam logic [5:0] K_LT  = 6'd8;
  localparam logic [5:0] K_LE  = 6'd9;
  localparam logic [5:0] K_NE  = 6'd10;
  localparam logic [5:0] K_GT  = 6'd11;
  localparam logic [5:0] K_GE  = 6'd12;
  localparam logic [5:0] K_SUB = 6'd13;
  localparam logic [5:0] K_ADD = 6'd14;
  localparam logic [5:0] K_MUL = 6'd15;
  localparam logic [5:0] K_DIV = 6'd16;
  localparam logic [5:0] K_IDV = 6'd17;
  localparam logic [5:0] K_LPA = 6'd18;
  localparam logic [5:0] K_RPA = 6'd19;
  localparam logic [5:0] K_LBR = 6'd20;
  localparam logic [5:0] K_RBR = 6'd21;
  localparam logic [5:0] K_SEM = 6'd22;
  localparam logic [5:0] K_DOT = 6'd23;
  localparam logic [5:0] K_COM = 6'd24;
  localparam logic [5:0] K_KW0 = 6'd25;

  // Character codes that the scanner tests for.
  localparam logic [7:0] C_QUOTE = 8'd39;
  localparam logic [7:0] C_BSL   = 8'd92;
  localparam logic [7:0] C_CTRL  = 8'd31;

  localparam int unsigned NumKeywords = 34;
  localparam int unsigned KwSpell     = 8;

  // Keyword spellings, first letter in the lowest byte, zero padded.
  localparam logic [KwSpell*8-1:0] KwTable [NumKeywords] = '{
    64'h0000_0000_0000_7361, // as
    64'h0000_0000_0063_7361, // asc
    64'h0065_7261_6c63_6564, // declare
    64'h0000_0000_006d_6964, // dim
    64'h0000_0000_0000_6f64, // do
    64'h0000_656c_6275_6f64, // double
    64'h0000_0000_6573_6c65, // else
    64'h0000_0000_0064_6e65, // end
    64'h6e6f_6974_636e_7566, // function
    64'h0000_0000_0000_6669, // if
    64'h0000_0074_7570_6e69, // input
    64'h0072_6567_6574_6e69, // integer
    64'h0000_6874_676e_656c, // length
    64'h0000_0000_706f_6f6c, // loop
    64'h0000_0074_6e69_7270, // print
    64'h0000_6e72_7574_6572, // return
    64'h0000_0065_706f_6373, // scope
    64'h0000_676e_6972_7473, // string
    64'h0000_7274_7362_7573, // substr
    64'h0000_0000_6e65_6874, // then
    64'h0000_0065_6c69_6877, // while
    64'h0000_0000_0064_6e61, // and
    64'h006e_6165_6c6f_6f62, // boolean
    64'h6575_6e69_746e_6f63, // continue
    64'h0000_6669_6573_6c65, // elseif
    64'h0000_0000_7469_7865, // exit
    64'h0000_0065_736c_6166, // false
    64'h0000_0000_0072_6f66, // for
    64'h0000_0000_7478_656e, // next
    64'h0000_0000_0074_6f6e, // not
    64'h0000_0000_0000_726f, // or
    64'h0000_6465_7261_6873, // shared
    64'h0000_6369_7461_7473, // static
    64'h0000_0000_6575_7274  // true
  };

  // Length of each keyword spelling.
  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd2, 4'd3, 4'd7, 4'd3, 4'd2, 4'd6, 4'd4, 4'd3, 4'd8, 4'd2, 4'd5, 4'd7,
    4'd6, 4'd4, 4'd5, 4'd6, 4'd5, 4'd6, 4'd6, 4'd4, 4'd5, 4'd3, 4'd7, 4'd8,
    4'd6, 4'd4, 4'd5, 4'd3, 4'd4, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4
  };

  // Operator kind of a character, or K_ERR when it is no operator.
  function automatic logic [5:0] op_of(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h3d:   k = K_EQ;
      8'h3c:   k = K_LT;
      8'h3e:   k = K_GT;
      8'h2d:   k = K_SUB;
      8'h2b:   k = K_ADD;
      8'h2a:   k = K_MUL;
      C_BSL:   k = K_IDV;
      8'h28:   k = K_LPA;
      8'h29:   k = K_RPA;
      8'h7b:   k = K_LBR;
      8'h7d:   k = K_RBR;
      8'h3b:   k = K_SEM;
      8'h2e:   k = K_DOT;
      8'h2c:   k = K_COM;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

// ----- src/bdl_scan.sv -----
// ============================================================================
// bdl_scan: scanner front end.
// Takes one character or end-of-file request per cycle while bnd_ready_i is
// high, steps the scanner state and forms the bundle of up to three results.
// ============================================================================
module bdl_scan import bdl_pkg::*; #(
  parameter int unsigned KeywordChars = KeywordCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bdl_in_t     in_data_i,
  output logic        bnd_valid_o,
  input  logic        bnd_ready_i,
  output bdl_bundle_t bnd_data_o
);

  localparam int unsigned LenW = $clog2(KeywordChars + 2);
  localparam int unsigned IdxW = $clog2(KeywordChars);
  localparam logic [LenW-1:0] LenSat = LenW'(KeywordChars + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(KeywordChars);

  bdl_state_e        state_q, state_d;
  logic              exp_q, exp_d;
  logic              dreq_q, dreq_d;
  logic [1:0]        edc_q, edc_d;
  logic [7:0]        kwb_q [KeywordChars];
  logic [7:0]        kwb_d [KeywordChars];
  logic [LenW-1:0]   len_q, len_d;
  logic              cq_q, cq_d;
  logic [5:0]        opk_q, opk_d;
  logic [9:0]        ev_q, ev_d;
  logic [5:0]        idk;

  // Results of this request.
  bdl_out_t    res [MaxResults];
  logic [1:0]  cnt;

  // A request is taken whenever the queue can hold a bundle.
  assign in_ready_o  = bnd_ready_i;
  assign bnd_valid_o = in_valid_i;

  // Keyword lookup over the stored identifier prefix.
  always_comb begin
    logic hit;
    idk = K_ID;
    for (int k = 0; k < NumKeywords; k++) begin
      hit = (len_q == LenW'(KwLen[k]));
      for (int i = 0; i < KeywordChars; i++) begin
        if (i < KwSpell) begin
          if (kwb_q[i] != KwTable[k][i*8 +: 8]) hit = 1'b0;
        end else if (kwb_q[i] != 8'd0) begin
          hit = 1'b0;
        end
      end
      if (hit && (len_q <= LenMax)) idk = K_KW0 + 6'(k);
    end
  end

  // Next state and results.
  always_comb begin
    logic [7:0] c;
    logic       rescan;
    logic [9:0] ev_n;
    logic [1:0] edc_n;
    c = in_data_i.char_code;
    state_d = state_q;
    exp_d = exp_q;
    dreq_d = dreq_q;
    edc_d = edc_q;
    kwb_d = kwb_q;
    len_d = len_q;
    cq_d = cq_q;
    opk_d = opk_q;
    ev_d = ev_q;
    cnt = 2'd0;
    rescan = 1'b0;
    ev_n = '0;
    edc_n = '0;
    for (int r = 0; r < MaxResults; r++) res[r] = '0;

    if (in_data_i.end_of_file) begin
      case (state_q)
        S_ID: begin
          res[cnt].token_kind = idk; cnt = cnt + 2'd1;
        end
        S_INT: begin
          res[cnt].token_kind = K_INT; cnt = cnt + 2'd1;
        end
        S_DBL: begin
          res[cnt].token_kind = dreq_q ? K_ERR : K_DBL; cnt = cnt + 2'd1;
        end
        S_OP: begin
          res[cnt].token_kind = opk_q; cnt = cnt + 2'd1;
        end
        S_SLASH: begin
          res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = 8'h2f;
          cnt = cnt + 2'd1;
          res[cnt].token_kind = K_DIV; cnt = cnt + 2'd1;
        end
        S_EXPW, S_BANG, S_STR, S_ESC, S_DDD, S_BCOM: begin
          res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      res[cnt].token_kind = K_EOF; cnt = cnt + 2'd1;
      state_d = S_START;
      exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0; cq_d = 1'b0; ev_d = '0;
      for (int i = 0; i < KeywordChars; i++) kwb_d[i] = '0;
      len_d = '0;
      opk_d = '0;
    end else begin
      // First pass: the current state; it may end a token and ask for a rescan.
      case (state_q)
        S_START, S_LCOM: begin
          if (state_q == S_START || c == 8'h0a) rescan = 1'b1;
        end
        S_ID: begin
          if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
            if (len_q < LenMax) kwb_d[len_q[IdxW-1:0]] = (c >= 8'h41 && c <= 8'h5a)
                ? c + 8'd32 : c;
            if (len_q < LenSat) len_d = len_q + 1'b1;
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          end else begin
            res[cnt].token_kind = idk; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_INT: begin
          if (is_digit(c)) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          end else if (c == 8'h2e) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            dreq_d = 1'b1; state_d = S_DBL;
          end else if (c == 8'h65 || c == 8'h45) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            exp_d = 1'b1; state_d = S_EXPW;
          end else begin
            res[cnt].token_kind = K_INT; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_DBL: begin
          if (dreq_q) begin
            if (is_digit(c)) begin
              res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c;
              cnt = cnt + 2'd1; dreq_d = 1'b0;
            end else begin
              res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1; rescan = 1'b1;
            end
          end else if (is_digit(c)) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          end else if ((c == 8'h65 || c == 8'h45) && !exp_q) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            exp_d = 1'b1; state_d = S_EXPW;
          end else begin
            res[cnt].token_kind = K_DBL; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_EXPW: begin
          if (c == 8'h2b || c == 8'h2d) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            dreq_d = 1'b1; state_d = S_DBL;
          end else if (is_digit(c)) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            state_d = S_DBL;
          end else begin
            res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_OP: begin
          if ((opk_q == K_LT && c == 8'h3d) || (opk_q == K_LT && c == 8'h3e)
              || (opk_q == K_GT && c == 8'h3d)) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
            res[cnt].token_kind = (opk_q == K_GT) ? K_GE : ((c == 8'h3d) ? K_LE : K_NE);
            cnt = cnt + 2'd1;
            state_d = S_START; exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0;
            cq_d = 1'b0; ev_d = '0;
          end else begin
            res[cnt].token_kind = opk_q; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_SLASH: begin
          if (c == C_QUOTE) begin
            cq_d = 1'b0; state_d = S_BCOM;
          end else begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = 8'h2f;
            cnt = cnt + 2'd1;
            res[cnt].token_kind = K_DIV; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_BANG: begin
          if (c == 8'h22) begin
            state_d = S_STR;
          end else begin
            res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_STR: begin
          if (c == 8'h22) begin
            res[cnt].token_kind = K_STR; cnt = cnt + 2'd1;
            state_d = S_START; exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0;
            cq_d = 1'b0; ev_d = '0;
          end else if (c == C_BSL) begin
            state_d = S_ESC;
          end else if (c > C_CTRL) begin
            res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          end
        end
        S_ESC: begin
          if (c == 8'h22 || c == 8'h6e || c == 8'h74 || c == C_BSL) begin
            res[cnt].is_lexeme_char = 1'b1;
            res[cnt].char_value = (c == 8'h6e) ? 8'd10 : ((c == 8'h74) ? 8'd9 : c);
            cnt = cnt + 2'd1; state_d = S_STR;
          end else if (is_digit(c)) begin
            ev_d = 10'(c - 8'h30); edc_d = '0; state_d = S_DDD;
          end
        end
        S_DDD: begin
          if (is_digit(c)) begin
            ev_n = 10'((ev_q << 3) + (ev_q << 1) + 10'(c - 8'h30));
            edc_n = edc_q + 2'd1;
            ev_d = ev_n; edc_d = edc_n;
            if (edc_n >= 2'd2) begin
              if (ev_n <= 10'd255) begin
                res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = ev_n[7:0];
                cnt = cnt + 2'd1;
                ev_d = '0; edc_d = '0; state_d = S_STR;
              end else begin
                res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1;
                state_d = S_START; exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0;
                cq_d = 1'b0; ev_d = '0;
              end
            end
          end else begin
            res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1; rescan = 1'b1;
          end
        end
        S_BCOM: begin
          if (cq_q && c == 8'h2f) begin
            state_d = S_START; exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0;
            cq_d = 1'b0; ev_d = '0;
          end else begin
            cq_d = (c == C_QUOTE);
          end
        end
        default: rescan = 1'b1;
      endcase

      // Second pass: the start state sees the character.
      if (rescan) begin
        state_d = S_START; exp_d = 1'b0; dreq_d = 1'b0; edc_d = '0;
        cq_d = 1'b0; ev_d = '0;
        if (c == 8'h0a) begin
          res[cnt].token_kind = K_EOL; cnt = cnt + 2'd1;
        end else if (c == 8'h20 || c == 8'd9 || c == 8'd11 || c == 8'd12
                     || c == 8'd13) begin
          state_d = S_START;
        end else if (c == C_QUOTE) begin
          state_d = S_LCOM;
        end else if (c == 8'h2f) begin
          state_d = S_SLASH;
        end else if (is_alpha(c) || c == 8'h5f) begin
          for (int i = 0; i < KeywordChars; i++) kwb_d[i] = '0;
          kwb_d[0] = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
          len_d = LenW'(1);
          res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          state_d = S_ID;
        end else if (is_digit(c)) begin
          res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          state_d = S_INT;
        end else if (c == 8'h21) begin
          state_d = S_BANG;
        end else if (op_of(c) != K_ERR) begin
          res[cnt].is_lexeme_char = 1'b1; res[cnt].char_value = c; cnt = cnt + 2'd1;
          opk_d = op_of(c); state_d = S_OP;
        end else begin
          res[cnt].token_kind = K_ERR; cnt = cnt + 2'd1;
        end
      end
    end

    // Mark the final result of the request.
    if (cnt != 2'd0) res[cnt - 2'd1].last_result = 1'b1;
  end

  assign bnd_data_o.count = cnt;
  assign bnd_data_o.r0    = res[0];
  assign bnd_data_o.r1    = res[1];
  assign bnd_data_o.r2    = res[2];

  // Scanner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      exp_q   <= 1'b0;
      dreq_q  <= 1'b0;
      edc_q   <= '0;
      len_q   <= '0;
      cq_q    <= 1'b0;
      opk_q   <= '0;
      ev_q    <= '0;
      for (int i = 0; i < KeywordChars; i++) kwb_q[i] <= '0;
    end else if (in_valid_i && in_ready_o) begin
      state_q <= state_d;
      exp_q   <= exp_d;
      dreq_q  <= dreq_d;
      edc_q   <= edc_d;
      len_q   <= len_d;
      cq_q    <= cq_d;
      opk_q   <= opk_d;
      ev_q    <= ev_d;
      kwb_q   <= kwb_d;
    end
  end

endmodule

// ----- src/bdl_emit.sv -----
// ============================================================================
// bdl_emit: back end.
// Holds a short queue of result bundles and sends their results out one per
// cycle while out_ready_i is high, in order.
// ============================================================================
module bdl_emit import bdl_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        bnd_valid_i,
  output logic        bnd_ready_o,
  input  bdl_bundle_t bnd_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bdl_out_t    out_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bdl_bundle_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      sub_q, sub_d;
  logic            push, pop, head_ok;
  bdl_bundle_t     head;

  assign head        = mem_q[rd_q];
  assign head_ok     = (cnt_q != '0) && (head.count != 2'd0);
  assign bnd_ready_o = (cnt_q != CntW'(Depth));
  // A bundle with no results is never stored.
  assign push        = bnd_valid_i && bnd_ready_o && (bnd_data_i.count != 2'd0);

  // Pick the current result from the head bundle.
  always_comb begin
    case (sub_q)
      2'd0:    out_data_o = head.r0;
      2'd1:    out_data_o = head.r1;
      default: out_data_o = head.r2;
    endcase
  end
  assign out_valid_o = head_ok;

  // Step through the head bundle; it leaves after its last result.
  always_comb begin
    pop   = 1'b0;
    sub_d = sub_q;
    if (out_valid_o && out_ready_i) begin
      if (sub_q + 2'd1 == head.count) begin
        pop   = 1'b1;
        sub_d = 2'd0;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sub_q <= sub_d;
      if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= bnd_data_i;
  end

endmodule

// ----- src/basic_dialect_lexer.sv -----
// ============================================================================
// basic_dialect_lexer: case-insensitive lexer for a BASIC-like language.
// A scanner front end feeds result bundles through a short queue to an
// emitter that sends one result per cycle while out_ready_i is high.
//
//   Channel | Handshake             | Payload
//   in      | in_valid_i/in_ready_o | in_data_i  (bdl_in_t)
//   out     | out_valid_o/out_ready_i | out_data_o (bdl_out_t)
//
// One character is taken per cycle while the queue has room; results leave
// one per cycle while out_ready_i is high, so a request with two or three
// results holds the output until all have left. Each bundle is registered in
// the queue before its results appear. Reset returns the scanner to its start
// state and empties the queue; output stalls back up through it to in_ready_o.
// ============================================================================
module basic_dialect_lexer import bdl_pkg::*; #(
  parameter int unsigned KeywordChars = KeywordCharsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bdl_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bdl_out_t out_data_o
);

  logic        bnd_valid, bnd_ready;
  bdl_bundle_t bnd_data;

  // Front end: scanner.
  bdl_scan #(.KeywordChars(KeywordChars)) u_scan (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready),
    .bnd_data_o  (bnd_data)
  );

  // Back end: queue and emitter.
  bdl_emit #(.Depth(QueueDepth)) u_emit (
    .clk_i,
    .rst_ni,
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .bnd_data_i  (bnd_data),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
